// ===== design/bvfo_pkg.sv =====
// Shared types, codes and band tables for the band VFO tuning controller.
`default_nettype none

package bvfo_pkg;

    localparam int FreqW = 24;
    localparam int DdsW  = 25;
    localparam int StepW = 16;
    localparam int PosW  = 16;
    localparam int BandW = 2;
    localparam int CodeW = 4;
    localparam int CfgW  = 24;

    // Item kinds
    localparam logic OpEncoder = 1'b0;
    localparam logic OpBand    = 1'b1;

    // Configuration register indexes
    localparam logic CfgIfOffset = 1'b0;
    localparam logic CfgTuneStep = 1'b1;

    localparam logic [CfgW-1:0]  IfOffsetRst = 24'd8865000;
    localparam logic [StepW-1:0] TuneStepRst = 16'd50;

    // Band indexes
    localparam logic [BandW-1:0] Band20 = 2'd0;
    localparam logic [BandW-1:0] Band40 = 2'd1;
    localparam logic [BandW-1:0] Band80 = 2'd2;

    localparam logic [PosW-1:0] PosOrigin = 16'h8000;

    typedef struct packed {
        logic             op;
        logic [PosW-1:0]  encoder_count;
        logic [2:0]       band_flags;
    } t_in;

    typedef struct packed {
        logic             updated;
        logic [FreqW-1:0] tune_freq_hz;
        logic [DdsW-1:0]  dds_freq_hz;
        logic [CodeW-1:0] filter_sel;
        logic [FreqW-1:0] display_bcd;
    } t_out;

    // Result of the state update, before display formatting
    typedef struct packed {
        logic             updated;
        logic [FreqW-1:0] freq;
        logic [CodeW-1:0] filter_sel;
    } t_mid;

    function automatic logic [FreqW-1:0] band_max(input logic [BandW-1:0] b);
        logic [FreqW-1:0] v;
        case (b)
            Band20:  v = 24'd14350000;
            Band40:  v = 24'd7200000;
            Band80:  v = 24'd3800000;
            default: v = 24'd14350000;
        endcase
        return v;
    endfunction

    function automatic logic [FreqW-1:0] band_def(input logic [BandW-1:0] b);
        logic [FreqW-1:0] v;
        case (b)
            Band20:  v = 24'd14175000;
            Band40:  v = 24'd7100000;
            Band80:  v = 24'd3650000;
            default: v = 24'd14175000;
        endcase
        return v;
    endfunction

    function automatic logic [FreqW-1:0] band_min(input logic [BandW-1:0] b);
        logic [FreqW-1:0] v;
        case (b)
            Band20:  v = 24'd14000000;
            Band40:  v = 24'd7000000;
            Band80:  v = 24'd3500000;
            default: v = 24'd14000000;
        endcase
        return v;
    endfunction

    function automatic logic [CodeW-1:0] filter_sel_of(input logic [BandW-1:0] b);
        logic [CodeW-1:0] v;
        case (b)
            Band20:  v = 4'b0010;
            Band40:  v = 4'b0100;
            Band80:  v = 4'b1000;
            default: v = 4'b0000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/bvfo_core.sv =====
// Tuning state: band switching with per-band frequency memory and encoder stepping.
`default_nettype none

module bvfo_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire bvfo_pkg::t_in               i_item,
    input  wire logic [bvfo_pkg::StepW-1:0]  i_step,
    output bvfo_pkg::t_mid                   o_res
);

    logic [bvfo_pkg::PosW-1:0]  r_last, n_last;
    logic [bvfo_pkg::FreqW-1:0] r_freq, n_freq;
    logic [bvfo_pkg::BandW-1:0] r_band, n_band;
    logic                       r_sel, n_sel;
    logic [bvfo_pkg::FreqW-1:0] r_saved [0:2];
    logic [bvfo_pkg::FreqW-1:0] n_saved [0:2];

    logic                       upd;
    logic                       nb_vld;
    logic [bvfo_pkg::BandW-1:0] nb;
    logic [bvfo_pkg::FreqW-1:0] ld;
    logic [bvfo_pkg::PosW-1:0]  pos;
    logic signed [bvfo_pkg::PosW:0] delta;
    logic [bvfo_pkg::FreqW-1:0] fmax, fmin;
    logic [bvfo_pkg::FreqW:0]   sum;
    logic [bvfo_pkg::FreqW-1:0] room;

    always_comb begin
        nb_vld = |i_item.band_flags;
        if (i_item.band_flags[2]) begin
            nb = bvfo_pkg::Band80;
        end else if (i_item.band_flags[1]) begin
            nb = bvfo_pkg::Band40;
        end else begin
            nb = bvfo_pkg::Band20;
        end
        ld    = r_saved[nb];
        pos   = bvfo_pkg::PosOrigin - i_item.encoder_count;
        delta = $signed({pos[bvfo_pkg::PosW-1], pos})
              - $signed({r_last[bvfo_pkg::PosW-1], r_last});
        fmax  = bvfo_pkg::band_max(r_band);
        fmin  = bvfo_pkg::band_min(r_band);
        sum   = {1'b0, r_freq} + {{(bvfo_pkg::FreqW + 1 - bvfo_pkg::StepW){1'b0}}, i_step};
        room  = r_freq - fmin;

        n_last = r_last;
        n_freq = r_freq;
        n_band = r_band;
        n_sel  = r_sel;
        for (int i = 0; i < 3; i++) begin
            n_saved[i] = r_saved[i];
        end
        upd = 1'b0;

        if (i_item.op == bvfo_pkg::OpBand) begin
            if (nb_vld && (!r_sel || nb != r_band)) begin
                if (r_sel) begin
                    n_saved[r_band] = r_freq;
                end
                // fall back to the band default when the stored value is out of band
                if (ld > bvfo_pkg::band_max(nb) || ld < bvfo_pkg::band_min(nb)) begin
                    n_freq = bvfo_pkg::band_def(nb);
                end else begin
                    n_freq = ld;
                end
                n_band = nb;
                n_sel  = 1'b1;
                upd    = 1'b1;
            end
        end else if (r_sel) begin
            if (pos != r_last) begin
                n_last = pos;
                if (delta > -17'sd10 && delta < 17'sd10) begin
                    upd = 1'b1;
                    if (delta[bvfo_pkg::PosW]) begin
                        // counter ran forwards (position fell): step up, saturate at the top edge
                        if (r_freq >= fmax || sum > {1'b0, fmax}) begin
                            n_freq = fmax;
                        end else begin
                            n_freq = sum[bvfo_pkg::FreqW-1:0];
                        end
                    end else begin
                        if (r_freq <= fmin
                            || room < {{(bvfo_pkg::FreqW - bvfo_pkg::StepW){1'b0}}, i_step}) begin
                            n_freq = fmin;
                        end else begin
                            n_freq = r_freq
                                   - {{(bvfo_pkg::FreqW - bvfo_pkg::StepW){1'b0}}, i_step};
                        end
                    end
                end
            end
        end

        o_res.updated    = upd;
        o_res.freq       = n_freq;
        o_res.filter_sel = n_sel ? bvfo_pkg::filter_sel_of(n_band) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_freq <= '0;
            r_band <= bvfo_pkg::Band20;
            r_sel  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_saved[i] <= '0;
            end
        end else if (i_adv) begin
            r_last <= n_last;
            r_freq <= n_freq;
            r_band <= n_band;
            r_sel  <= n_sel;
            for (int i = 0; i < 3; i++) begin
                r_saved[i] <= n_saved[i];
            end
        end
    end

    a_band_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> (r_band == bvfo_pkg::Band20 || r_band == bvfo_pkg::Band40
                   || r_band == bvfo_pkg::Band80))
        else $error("active band index out of range");

    a_freq_in_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> (r_freq <= bvfo_pkg::band_max(r_band)
                   && r_freq >= bvfo_pkg::band_min(r_band)))
        else $error("tuned frequency outside band limits");

    a_idle_before_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sel |-> (r_freq == '0 && r_last == '0))
        else $error("state moved before any band was selected");

    a_upd_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_item.op == bvfo_pkg::OpEncoder && !r_sel) |-> !o_res.updated)
        else $error("encoder word acted on before band selection");

endmodule

`default_nettype wire

// ===== design/bvfo_disp.sv =====
// Six-digit BCD display formatting of the tuned frequency.
`default_nettype none

module bvfo_disp (
    input  wire logic [bvfo_pkg::FreqW-1:0] i_freq,
    output logic      [bvfo_pkg::FreqW-1:0] o_bcd
);

    localparam int NDig  = 6;
    localparam int ProdW = 49;

    // Exact reciprocals for 24-bit dividends: ceil(2^s / 10^k), k = 2..7
    localparam logic [24:0] Mag [0:NDig-1] = '{
        25'd21474837, 25'd17179870, 25'd27487791,
        25'd21990233, 25'd17592187, 25'd28147498
    };
    localparam int Shf [0:NDig-1] = '{31, 34, 38, 41, 44, 48};

    logic [ProdW-1:0]           prod [0:NDig-1];
    logic [bvfo_pkg::FreqW-1:0] quo  [0:NDig-1];

    always_comb begin
        for (int k = 0; k < NDig; k++) begin
            prod[k] = ProdW'(i_freq) * ProdW'(Mag[k]);
            quo[k]  = bvfo_pkg::FreqW'(prod[k] >> Shf[k]);
        end
        // each digit but the top one is its quotient less ten times the next one up
        for (int k = 0; k < NDig - 1; k++) begin
            o_bcd[4*k +: 4] = 4'(quo[k] - bvfo_pkg::FreqW'(quo[k+1] * 24'd10));
        end
        o_bcd[4*(NDig-1) +: 4] = quo[NDig-1][3:0];
    end

endmodule

`default_nettype wire

// ===== design/band_vfo_tuning_controller_unit.sv =====
// Top level of the three-band VFO tuning controller.
//
// Takes one word per cycle on the input channel and gives one result word per input word,
// in order. A word passes three registers: the input register, the tuning state update
// (band switch with per-band frequency recall, or one encoder step with clamping at the
// band edges), and the output register, where the synthesiser frequency and six BCD
// digits are formed by constant reciprocal multiplies. Throughput is one word per cycle,
// held back only by a stalled output. Configuration writes (IF offset, tuning step) take
// effect at once and are meant to be made with the pipeline empty.
`default_nettype none

module band_vfo_tuning_controller_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire bvfo_pkg::t_in               i_in,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output bvfo_pkg::t_out                   o_out,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_idx,
    input  wire logic [bvfo_pkg::CfgW-1:0]   i_cfg_data
);

    logic [bvfo_pkg::CfgW-1:0]  r_if_off;
    logic [bvfo_pkg::StepW-1:0] r_step;

    logic           r_in_vld, r_mid_vld, r_out_vld;
    bvfo_pkg::t_in  r_in;
    bvfo_pkg::t_mid r_mid;
    bvfo_pkg::t_mid core_res;
    bvfo_pkg::t_out r_out, n_out;
    logic [bvfo_pkg::FreqW-1:0] bcd;

    logic rdy_c, adv_c, rdy_b, adv_b, acc_in;

    always_comb begin
        rdy_c   = !r_out_vld || i_ready;
        adv_c   = r_mid_vld && rdy_c;
        rdy_b   = !r_mid_vld || rdy_c;
        adv_b   = r_in_vld && rdy_b;
        o_ready = !r_in_vld || rdy_b;
        acc_in  = i_valid && o_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_if_off <= bvfo_pkg::IfOffsetRst;
            r_step   <= bvfo_pkg::TuneStepRst;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bvfo_pkg::CfgIfOffset: r_if_off <= i_cfg_data;
                bvfo_pkg::CfgTuneStep: r_step   <= i_cfg_data[bvfo_pkg::StepW-1:0];
                default: ;
            endcase
        end
    end

    bvfo_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv_b),
        .i_item  (r_in),
        .i_step  (r_step),
        .o_res   (core_res)
    );

    bvfo_disp u_disp (
        .i_freq (r_mid.freq),
        .o_bcd  (bcd)
    );

    always_comb begin
        n_out.updated      = r_mid.updated;
        n_out.tune_freq_hz = r_mid.freq;
        n_out.dds_freq_hz  = bvfo_pkg::DdsW'(r_mid.freq) + bvfo_pkg::DdsW'(r_if_off);
        n_out.filter_sel   = r_mid.filter_sel;
        n_out.display_bcd  = bcd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_mid_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (acc_in) begin
                r_in_vld <= 1'b1;
            end else if (adv_b) begin
                r_in_vld <= 1'b0;
            end
            if (adv_b) begin
                r_mid_vld <= 1'b1;
            end else if (adv_c) begin
                r_mid_vld <= 1'b0;
            end
            if (adv_c) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers: load on advance, hold otherwise
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_in <= i_in;
        end
        if (adv_b) begin
            r_mid <= core_res;
        end
        if (adv_c) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_out   = r_out;

endmodule

`default_nettype wire
